### src/aprq_pkg.sv
package aprq_pkg;

	localparam int NUM_SLOTS     = 16;
	localparam int PRIORITY_BITS = 16;
	localparam int SLOT_W        = $clog2(NUM_SLOTS);

	// Port fields have fixed widths; these widen whichever side is narrower.
	localparam int SLOT_EXT_W = (SLOT_W > 4) ? SLOT_W : 4;
	localparam int PRIO_EXT_W = (PRIORITY_BITS > 16) ? PRIORITY_BITS : 16;

	typedef logic [SLOT_W-1:0]        slot_t;
	typedef logic [PRIORITY_BITS-1:0] prio_t;
	typedef logic [2:0]               func_t;
	typedef logic [1:0]               status_t;

	localparam prio_t PRIO_MAX = '1;

	localparam func_t FN_CLEAR    = 3'd0;
	localparam func_t FN_PUSH     = 3'd1;
	localparam func_t FN_FIFO_DEQ = 3'd2;
	localparam func_t FN_REMOVE   = 3'd3;
	localparam func_t FN_PRIO_DEQ = 3'd4;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_EMPTY      = 2'd1;
	localparam status_t ST_NOT_QUEUED = 2'd2;
	localparam status_t ST_QUEUED     = 2'd3;

	typedef struct packed {
		logic first;
		logic step;
	} age_ctl_t;

	function automatic slot_t slot_from_port(logic [3:0] x);
		logic [SLOT_EXT_W-1:0] ext;
		ext = SLOT_EXT_W'(x);
		return ext[SLOT_W-1:0];
	endfunction

	function automatic logic [3:0] slot_to_port(slot_t x);
		logic [SLOT_EXT_W-1:0] ext;
		ext = SLOT_EXT_W'(x);
		return ext[3:0];
	endfunction

	function automatic prio_t prio_from_port(logic [15:0] x);
		logic [PRIO_EXT_W-1:0] ext;
		ext = PRIO_EXT_W'(x);
		return ext[PRIORITY_BITS-1:0];
	endfunction

	function automatic logic [15:0] prio_to_port(prio_t x);
		logic [PRIO_EXT_W-1:0] ext;
		ext = PRIO_EXT_W'(x);
		return ext[15:0];
	endfunction

endpackage

### src/aprq_ram.sv
module aprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/aprq_age_unit.sv
module aprq_age_unit import aprq_pkg::*; (
	input  logic     clk,
	input  age_ctl_t ctl,
	input  slot_t    cur,
	input  prio_t    raw,
	output prio_t    aged,
	output slot_t    best_next,
	output slot_t    best_slot,
	output prio_t    best_val
);

	slot_t best_slot_q;
	prio_t best_val_q;
	logic  take_new;

	// Saturating increment, then a strict compare so the earliest slot wins ties.
	assign aged      = (raw < PRIO_MAX) ? raw + prio_t'(1) : raw;
	assign take_new  = ctl.first || (aged > best_val_q);
	assign best_next = take_new ? cur : best_slot_q;

	always_ff @(posedge clk) begin
		if (ctl.step && take_new) begin
			best_slot_q <= cur;
			best_val_q  <= aged;
		end
	end

	assign best_slot = best_slot_q;
	assign best_val  = best_val_q;

endmodule

### src/aging_priority_ready_queue.sv
// Ready queue of task slots held as a doubly linked list, one priority per slot.
// Items enter on func/slot_id/push_priority with item_valid/item_ready, and each
// item gives exactly one result on out_slot/out_valid/out_priority/queue_empty/
// status with result_valid/result_ready.
// Links and priorities live in three small RAMs that share one read address;
// membership, head, tail and the empty flag are flip-flops.
// Clear, push, an unused code or a rejected operation go from S_DECODE to
// S_DONE; FIFO dequeue and remove pass through S_LINK first, and priority
// dequeue first walks all queued slots in S_WALK. The
// priority walk ages and compares one slot per cycle in a single shared
// saturating increment and compare unit, following the next-link RAM.
// A new item can be taken only in S_IDLE, in the cycle after the previous
// result is loaded, so the block works on one item at a time.
// The result sits in an output register; while it waits the next item is
// already accepted, but a finished item waits for that register to be taken
// before the block becomes ready again.
// Reset empties the queue and drops any pending result; the link and priority
// RAMs are not cleared and are only read for queued slots.
module aging_priority_ready_queue import aprq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  func,
	input  logic [3:0]  slot_id,
	input  logic [15:0] push_priority,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [3:0]  out_slot,
	output logic        out_valid,
	output logic [15:0] out_priority,
	output logic        queue_empty,
	output logic [1:0]  status
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_WALK   = 5'b00100,
		S_LINK   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t               state_q;
	func_t                func_q;
	logic [3:0]           slot_in_q;
	prio_t                prio_q;
	logic [NUM_SLOTS-1:0] flags_q;
	slot_t                head_q;
	slot_t                tail_q;
	logic                 empty_q;
	slot_t                cur_q;
	slot_t                target_q;
	logic                 first_q;
	slot_t                pend_slot_q;
	logic                 pend_valid_q;
	prio_t                pend_prio_q;
	status_t              pend_status_q;
	logic                 res_valid_q;
	logic [3:0]           out_slot_q;
	logic                 out_valid_q;
	logic [15:0]          out_prio_q;
	logic                 queue_empty_q;
	status_t              status_q;

	logic     in_range;
	slot_t    s_idx;
	logic     is_member;
	logic     is_head;
	logic     is_tail;
	slot_t    raddr;
	slot_t    next_rd;
	slot_t    prev_rd;
	prio_t    prio_rd;
	logic     next_we;
	slot_t    next_waddr;
	slot_t    next_wdata;
	logic     prev_we;
	slot_t    prev_waddr;
	slot_t    prev_wdata;
	logic     prio_we;
	slot_t    prio_waddr;
	prio_t    prio_wdata;
	age_ctl_t age_ctl;
	prio_t    aged;
	slot_t    best_next;
	slot_t    best_slot;
	prio_t    best_val;

	assign in_range  = 32'(slot_in_q) < NUM_SLOTS;
	assign s_idx     = slot_from_port(slot_in_q);
	assign is_member = flags_q[s_idx];
	assign is_head   = (target_q == head_q);
	assign is_tail   = (target_q == tail_q);

	aprq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (raddr),
		.rdata (next_rd)
	);

	aprq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (raddr),
		.rdata (prev_rd)
	);

	aprq_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(NUM_SLOTS)) u_prio_ram (
		.clk   (clk),
		.we    (prio_we),
		.waddr (prio_waddr),
		.wdata (prio_wdata),
		.raddr (raddr),
		.rdata (prio_rd)
	);

	aprq_age_unit u_age (
		.clk       (clk),
		.ctl       (age_ctl),
		.cur       (cur_q),
		.raw       (prio_rd),
		.aged      (aged),
		.best_next (best_next),
		.best_slot (best_slot),
		.best_val  (best_val)
	);

	always_comb begin
		raddr      = head_q;
		next_we    = 1'b0;
		next_waddr = tail_q;
		next_wdata = s_idx;
		prev_we    = 1'b0;
		prev_waddr = s_idx;
		prev_wdata = tail_q;
		prio_we    = 1'b0;
		prio_waddr = s_idx;
		prio_wdata = prio_q;
		age_ctl    = '0;
		unique case (state_q)
			S_DECODE: begin
				raddr = (func_q == FN_REMOVE) ? s_idx : head_q;
				if (func_q == FN_PUSH && in_range && !is_member) begin
					prio_we = 1'b1;
					if (!empty_q) begin
						next_we = 1'b1;
						prev_we = 1'b1;
					end
				end
			end
			S_WALK: begin
				age_ctl.step = 1'b1;
				age_ctl.first = first_q;
				prio_we    = 1'b1;
				prio_waddr = cur_q;
				prio_wdata = aged;
				// The read for the next slot, or for the winner's links, goes out
				// in the same cycle that the current slot is aged.
				raddr = (cur_q == tail_q) ? best_next : next_rd;
			end
			S_LINK: begin
				if (!is_head && !is_tail) begin
					next_we    = 1'b1;
					next_waddr = prev_rd;
					next_wdata = next_rd;
					prev_we    = 1'b1;
					prev_waddr = next_rd;
					prev_wdata = prev_rd;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			func_q        <= FN_CLEAR;
			slot_in_q     <= '0;
			prio_q        <= '0;
			flags_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			empty_q       <= 1'b1;
			cur_q         <= '0;
			target_q      <= '0;
			first_q       <= 1'b0;
			pend_slot_q   <= '0;
			pend_valid_q  <= 1'b0;
			pend_prio_q   <= '0;
			pend_status_q <= ST_OK;
			res_valid_q   <= 1'b0;
			out_slot_q    <= '0;
			out_valid_q   <= 1'b0;
			out_prio_q    <= '0;
			queue_empty_q <= 1'b1;
			status_q      <= ST_OK;
		end else begin
			// In S_DONE a taken result is replaced by the new one below.
			if (res_valid_q && result_ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						func_q    <= func;
						slot_in_q <= slot_id;
						prio_q    <= prio_from_port(push_priority);
						state_q   <= S_DECODE;
					end
				end
				S_DECODE: begin
					pend_slot_q  <= '0;
					pend_valid_q <= 1'b0;
					pend_prio_q  <= '0;
					unique case (func_q)
						FN_CLEAR: begin
							flags_q       <= '0;
							head_q        <= '0;
							tail_q        <= '0;
							empty_q       <= 1'b1;
							pend_status_q <= ST_OK;
							state_q       <= S_DONE;
						end
						FN_PUSH: begin
							state_q <= S_DONE;
							if (!in_range) begin
								pend_status_q <= ST_NOT_QUEUED;
							end else if (is_member) begin
								pend_status_q <= ST_QUEUED;
							end else begin
								pend_status_q  <= ST_OK;
								flags_q[s_idx] <= 1'b1;
								tail_q         <= s_idx;
								if (empty_q) begin
									head_q <= s_idx;
								end
								empty_q <= 1'b0;
							end
						end
						FN_FIFO_DEQ: begin
							if (empty_q) begin
								pend_status_q <= ST_EMPTY;
								state_q       <= S_DONE;
							end else begin
								pend_status_q <= ST_OK;
								target_q      <= head_q;
								state_q       <= S_LINK;
							end
						end
						FN_REMOVE: begin
							if (!in_range || !is_member) begin
								pend_status_q <= ST_NOT_QUEUED;
								state_q       <= S_DONE;
							end else begin
								pend_status_q <= ST_OK;
								target_q      <= s_idx;
								state_q       <= S_LINK;
							end
						end
						FN_PRIO_DEQ: begin
							if (empty_q) begin
								pend_status_q <= ST_EMPTY;
								state_q       <= S_DONE;
							end else begin
								pend_status_q <= ST_OK;
								cur_q         <= head_q;
								first_q       <= 1'b1;
								state_q       <= S_WALK;
							end
						end
						default: begin
							pend_status_q <= ST_OK;
							state_q       <= S_DONE;
						end
					endcase
				end
				S_WALK: begin
					first_q <= 1'b0;
					if (cur_q == tail_q) begin
						target_q <= best_next;
						state_q  <= S_LINK;
					end else begin
						cur_q <= next_rd;
					end
				end
				S_LINK: begin
					flags_q[target_q] <= 1'b0;
					if (is_head && is_tail) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b1;
					end else if (is_head) begin
						head_q <= next_rd;
					end else if (is_tail) begin
						tail_q <= prev_rd;
					end
					priority if (func_q == FN_FIFO_DEQ) begin
						pend_slot_q  <= target_q;
						pend_valid_q <= 1'b1;
					end else if (func_q == FN_REMOVE) begin
						// Removing the tail leaves no following slot to report.
						if (!is_tail) begin
							pend_slot_q  <= next_rd;
							pend_valid_q <= 1'b1;
						end
					end else begin
						pend_slot_q  <= best_slot;
						pend_valid_q <= 1'b1;
						pend_prio_q  <= best_val;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || result_ready) begin
						out_slot_q    <= slot_to_port(pend_slot_q);
						out_valid_q   <= pend_valid_q;
						out_prio_q    <= prio_to_port(pend_prio_q);
						queue_empty_q <= empty_q;
						status_q      <= pend_status_q;
						res_valid_q   <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign out_slot     = out_slot_q;
	assign out_valid    = out_valid_q;
	assign out_priority = out_prio_q;
	assign queue_empty  = queue_empty_q;
	assign status       = status_q;

`ifndef ASSERT_OFF
	a_empty_no_members: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (flags_q == '0))
		else $error("Queue marked empty while slots are still members.");

	a_ends_are_members: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (flags_q[head_q] && flags_q[tail_q]))
		else $error("Head or tail of a non-empty queue is not a member.");

	a_walk_on_member: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> flags_q[cur_q])
		else $error("Priority walk reached a slot that is not queued.");

	a_error_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q != ST_OK) |-> !out_valid_q)
		else $error("Rejected item reports a valid slot.");
`endif

endmodule

### tb/ready_queue_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the ready queue, keeps its own copy of the list,
// and compares every result item against the oldest prediction.
module ready_queue_checker import aprq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [2:0]  func,
	input  logic [3:0]  slot_id,
	input  logic [15:0] push_priority,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [3:0]  out_slot,
	input  logic        out_valid,
	input  logic [15:0] out_priority,
	input  logic        queue_empty,
	input  logic [1:0]  status,
	output int          mismatches,
	output int          results_waiting,
	output int          results_checked
);

	typedef struct packed {
		logic [3:0]  slot;
		logic        valid;
		logic [15:0] prio;
		logic        empty;
		status_t     st;
	} queue_result_t;

	logic  queued    [NUM_SLOTS];
	slot_t link_next [NUM_SLOTS];
	slot_t link_prev [NUM_SLOTS];
	prio_t slot_prio [NUM_SLOTS];
	slot_t head;
	slot_t tail;
	logic  is_empty;

	queue_result_t expected_results [$];
	int            fail_tally;
	int            checked_tally;

	// Takes a queued slot out of the list and returns the slot that followed it.
	function automatic slot_t detach(slot_t s);
		slot_t n;
		slot_t p;
		n = link_next[s];
		p = link_prev[s];
		if (s == head && s == tail) begin
			head = '0;
			tail = '0;
			is_empty = 1'b1;
		end else if (s == head) begin
			head = n;
			link_prev[n] = '0;
		end else if (s == tail) begin
			tail = p;
			link_next[p] = '0;
		end else begin
			link_next[p] = n;
			link_prev[n] = p;
		end
		link_next[s] = '0;
		link_prev[s] = '0;
		queued[s] = 1'b0;
		return n;
	endfunction

	function automatic queue_result_t predict_queue_op(func_t f, logic [3:0] sid,
			logic [15:0] pin);
		queue_result_t r;
		slot_t         s;
		slot_t         n;
		slot_t         cur;
		slot_t         best;
		prio_t         p;
		prio_t         v;
		prio_t         best_val;
		logic          in_range;
		logic          follows;
		logic          walked;
		int            i;
		r = '0;
		in_range = int'(sid) < NUM_SLOTS;
		s = slot_t'(sid);
		p = prio_t'(pin);
		case (f)
			FN_CLEAR: begin
				for (i = 0; i < NUM_SLOTS; i++)
					queued[i] = 1'b0;
				head = '0;
				tail = '0;
				is_empty = 1'b1;
			end
			FN_PUSH: begin
				if (!in_range)
					r.st = ST_NOT_QUEUED;
				else if (queued[s])
					r.st = ST_QUEUED;
				else begin
					slot_prio[s] = p;
					link_next[s] = '0;
					if (is_empty) begin
						head = s;
						link_prev[s] = '0;
					end else begin
						link_next[tail] = s;
						link_prev[s] = tail;
					end
					tail = s;
					queued[s] = 1'b1;
					is_empty = 1'b0;
				end
			end
			FN_FIFO_DEQ: begin
				if (is_empty)
					r.st = ST_EMPTY;
				else begin
					n = head;
					void'(detach(n));
					r.slot = 4'(n);
					r.valid = 1'b1;
				end
			end
			FN_REMOVE: begin
				if (!in_range || !queued[s])
					r.st = ST_NOT_QUEUED;
				else begin
					follows = (s != tail);
					n = detach(s);
					if (follows) begin
						r.slot = 4'(n);
						r.valid = 1'b1;
					end
				end
			end
			FN_PRIO_DEQ: begin
				if (is_empty)
					r.st = ST_EMPTY;
				else begin
					// Age every queued slot; ties keep the earliest one in list order.
					cur = head;
					best = head;
					best_val = '0;
					walked = 1'b0;
					for (i = 0; i < NUM_SLOTS && !walked; i++) begin
						v = slot_prio[cur];
						if (v != PRIO_MAX)
							v = v + 1'b1;
						slot_prio[cur] = v;
						if (i == 0 || v > best_val) begin
							best = cur;
							best_val = v;
						end
						if (cur == tail)
							walked = 1'b1;
						else
							cur = link_next[cur];
					end
					void'(detach(best));
					r.slot = 4'(best);
					r.valid = 1'b1;
					r.prio = 16'(best_val);
				end
			end
			default: begin
			end
		endcase
		r.empty = is_empty;
		return r;
	endfunction

	task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			fail_tally++;
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		queue_result_t want;
		int            i;
		if (!arst_n) begin
			for (i = 0; i < NUM_SLOTS; i++) begin
				queued[i] = 1'b0;
				link_next[i] = '0;
				link_prev[i] = '0;
				slot_prio[i] = '0;
			end
			head = '0;
			tail = '0;
			is_empty = 1'b1;
			expected_results.delete();
			fail_tally = 0;
			checked_tally = 0;
			mismatches <= 0;
			results_waiting <= 0;
			results_checked <= 0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(predict_queue_op(func, slot_id, push_priority));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					fail_tally++;
					$display("%0t ns: result item with none expected, got slot 0x%0h status %0d",
						$time, out_slot, status);
				end else begin
					want = expected_results.pop_front();
					checked_tally++;
					check_field("out_slot", 16'(want.slot), 16'(out_slot));
					check_field("out_valid", 16'(want.valid), 16'(out_valid));
					check_field("out_priority", want.prio, out_priority);
					check_field("queue_empty", 16'(want.empty), 16'(queue_empty));
					check_field("status", 16'(want.st), 16'(status));
				end
			end
			mismatches <= fail_tally;
			results_waiting <= expected_results.size();
			results_checked <= checked_tally;
		end
	end

endmodule

### tb/aging_priority_ready_queue_tb.sv
`timescale 1ns / 100ps

module aging_priority_ready_queue_tb;
	import aprq_pkg::*;

	localparam int    LIMIT_CYCLES = 400000;
	localparam int    LONG_HOLD    = 400;
	localparam int    CHUNKS       = 10;
	localparam int    CHUNK_ITEMS  = 100;
	localparam func_t FN_SPARE_LO  = 3'd5;
	localparam func_t FN_SPARE_HI  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [2:0]  func;
	logic [3:0]  slot_id;
	logic [15:0] push_priority;
	logic        result_valid;
	logic        result_ready;
	logic [3:0]  out_slot;
	logic        out_valid;
	logic [15:0] out_priority;
	logic        queue_empty;
	logic [1:0]  status;

	int mismatches;
	int results_waiting;
	int results_checked;

	int cycle_count = 0;
	int op_count [8];
	int idle_pct;
	int stall_pct;
	bit calm;
	bit hold_request;

	aging_priority_ready_queue i_dut (.*);

	ready_queue_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: short random stalls, a long hold-off on request, none when calm.
	initial begin
		result_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic offer_item(func_t f, logic [3:0] sid, logic [15:0] p);
		item_valid <= 1'b1;
		func <= f;
		slot_id <= sid;
		push_priority <= p;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		op_count[f]++;
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
	endtask

	// Priorities lean toward the top of the range so that aging saturates.
	function automatic logic [15:0] pick_priority();
		case ($urandom_range(0, 7))
			0: return '0;
			1, 2: return 16'hFFFF - 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic offer_random_item(int push_pct);
		int    roll;
		func_t f;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			f = FN_CLEAR;
		else if (roll < 4)
			f = func_t'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		else if (roll < 4 + push_pct)
			f = FN_PUSH;
		else begin
			case ($urandom_range(0, 3))
				0: f = FN_FIFO_DEQ;
				1: f = FN_REMOVE;
				default: f = FN_PRIO_DEQ;
			endcase
		end
		offer_item(f, 4'($urandom), pick_priority());
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = FN_CLEAR;
		slot_id = '0;
		push_priority = '0;
		idle_pct = 0;
		stall_pct = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Errors on an empty queue and on a slot that was never queued.
		offer_item(FN_FIFO_DEQ, 4'd0, 16'h0000);
		offer_item(FN_PRIO_DEQ, 4'd0, 16'h0000);
		offer_item(FN_REMOVE, 4'd15, 16'h0000);
		// Saturation: the two top slots both age to the maximum.
		offer_item(FN_PUSH, 4'd0, 16'h0000);
		offer_item(FN_PUSH, 4'd15, 16'hFFFF);
		offer_item(FN_PUSH, 4'd0, 16'h1234);
		offer_item(FN_PUSH, 4'd7, 16'hFFFE);
		offer_item(FN_PRIO_DEQ, 4'd0, 16'h0000);
		offer_item(FN_PRIO_DEQ, 4'd0, 16'h0000);
		offer_item(FN_REMOVE, 4'd0, 16'h0000);
		// Remove from the middle, the tail and the head.
		offer_item(FN_PUSH, 4'd3, 16'h1234);
		offer_item(FN_PUSH, 4'd9, 16'h00FF);
		offer_item(FN_PUSH, 4'd12, 16'hABCD);
		offer_item(FN_PUSH, 4'd10, 16'h5555);
		offer_item(FN_REMOVE, 4'd9, 16'h0000);
		offer_item(FN_REMOVE, 4'd10, 16'h0000);
		offer_item(FN_REMOVE, 4'd3, 16'h0000);
		offer_item(FN_FIFO_DEQ, 4'd0, 16'h0000);
		for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++)
			offer_item(func_t'(f), 4'($urandom), 16'($urandom));
		// Equal priorities resolve to the earlier slot in the list.
		offer_item(FN_PUSH, 4'd4, 16'd100);
		offer_item(FN_PUSH, 4'd6, 16'd100);
		offer_item(FN_PRIO_DEQ, 4'd0, 16'h0000);
		offer_item(FN_PUSH, 4'd1, 16'h0F0F);
		offer_item(FN_CLEAR, 4'd0, 16'h0000);
		offer_item(FN_FIFO_DEQ, 4'd0, 16'h0000);
		offer_item(FN_PUSH, 4'd6, 16'hFFFF);
		wait_for_drain();

		// Hold the result side for a long stretch while items keep coming.
		hold_request = 1'b1;
		repeat (24) offer_random_item(70);

		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			if (chunk == CHUNKS / 2)
				wait_for_drain();
			calm = (chunk == CHUNKS - 1);
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			repeat (CHUNK_ITEMS) offer_random_item($urandom_range(25, 75));
		end

		wait_for_drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d pushes, %0d FIFO dequeues, %0d removes, %0d priority dequeues,",
			op_count[FN_PUSH], op_count[FN_FIFO_DEQ], op_count[FN_REMOVE],
			op_count[FN_PRIO_DEQ]);
		$display("%0d clears and %0d unused codes; %0d results checked in %0d cycles.",
			op_count[FN_CLEAR], op_count[5] + op_count[6] + op_count[7],
			results_checked, cycle_count);
		if (mismatches == 0 && results_waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
